// ===== hdl/tlpq_pkg.sv =====
// ---------------------------------------------------------------------------
// tlpq_pkg: shared types and codes of the three-level priority queue
// Holds the stored slot record, the scan status flags and the operation,
// status and level codes.
// ---------------------------------------------------------------------------
package tlpq_pkg;

   localparam int KEY_W     = 40;
   localparam int PAYLOAD_W = 8;
   localparam int LEVEL_W   = 2;
   localparam int STAMP_W   = 8;
   localparam int STATUS_W  = 2;
   localparam int TDATA_W   = 56;

   // Operation codes carried on the request side.
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Priority levels, red is the most urgent.
   localparam logic [LEVEL_W-1:0] LVL_NONE   = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_GREEN  = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_YELLOW = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_RED    = 2'd3;

   // One stored entry as held in the slot memory.
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEVEL_W-1:0]   level;
      logic [STAMP_W-1:0]   stamp;
   } slot_entry_type;

   // Summary flags produced by one pass over the slots.
   typedef struct packed {
      logic dup;
      logic free_found;
      logic best_found;
   } scan_status_type;

endpackage

// ===== hdl/tlpq_mem.sv =====
// ---------------------------------------------------------------------------
// tlpq_mem: slot memory
// Single write port and single read port, read data registered.
// ---------------------------------------------------------------------------
module tlpq_mem #(
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  tlpq_pkg::slot_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output tlpq_pkg::slot_entry_type        rd_data
);
   import tlpq_pkg::*;

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tlpq_scan.sv =====
// ---------------------------------------------------------------------------
// tlpq_scan: slot scan unit
// Looks at one slot per enabled cycle and keeps the duplicate flag, the lowest
// free slot and the oldest entry of the highest level seen so far.
// ---------------------------------------------------------------------------
module tlpq_scan #(
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  cmp_en,
   input  logic [$clog2(DEPTH)-1:0]              cmp_idx,
   input  logic                                  cmp_valid,
   input  tlpq_pkg::slot_entry_type              cmp_entry,
   input  logic [tlpq_pkg::KEY_W-1:0]            req_key,
   input  logic [tlpq_pkg::STAMP_W-1:0]          counter,
   output tlpq_pkg::scan_status_type             status,
   output logic [$clog2(DEPTH)-1:0]              free_idx,
   output logic [$clog2(DEPTH)-1:0]              best_idx,
   output tlpq_pkg::slot_entry_type              best_entry
);
   import tlpq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   scan_status_type      status_ff, status_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   slot_entry_type       best_entry_ff, best_entry_in;
   logic [STAMP_W-1:0]   best_age_ff, best_age_in;
   logic [STAMP_W-1:0]   age;
   logic                 better;

   // Age wraps modulo 256; a larger distance from the counter is older.
   assign age = counter - cmp_entry.stamp;

   assign better = !status_ff.best_found
                   || (cmp_entry.level > best_entry_ff.level)
                   || ((cmp_entry.level == best_entry_ff.level) && (age > best_age_ff));

   always_comb begin
      status_in     = status_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_entry_in = best_entry_ff;
      best_age_in   = best_age_ff;
      if (clear) begin
         status_in = '0;
      end else if (cmp_en) begin
         if (cmp_valid) begin
            if (cmp_entry.key == req_key) begin
               status_in.dup = 1'b1;
            end
            if (better) begin
               status_in.best_found = 1'b1;
               best_idx_in          = cmp_idx;
               best_entry_in        = cmp_entry;
               best_age_in          = age;
            end
         end else if (!status_ff.free_found) begin
            status_in.free_found = 1'b1;
            free_idx_in          = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
      end else begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_entry_ff <= best_entry_in;
      best_age_ff   <= best_age_in;
   end

   assign status     = status_ff;
   assign free_idx   = free_idx_ff;
   assign best_idx   = best_idx_ff;
   assign best_entry = best_entry_ff;

endmodule

// ===== hdl/three_level_priority_queue_unit.sv =====
// ---------------------------------------------------------------------------
// three_level_priority_queue_unit: three-level priority queue, FIFO per level
// Requests are taken one at a time: a new one is accepted only once the last is
// through its DEPTH reads on the single memory read port, the last read data, the
// end of scan and the commit, which waits for the result register to be free.
// Reset: synchronous, clears all slot valid bits, the arrival counter and the
// control state; the slot memory itself is not cleared.
// ---------------------------------------------------------------------------
module three_level_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tuser: operation (bit 0).
   input  logic                               req_tuser,
   // tdata: key [39:0], payload [47:40], level [49:48], zero [55:50].
   input  logic [tlpq_pkg::TDATA_W-1:0]       req_tdata,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tuser: status [1:0].
   output logic [tlpq_pkg::STATUS_W-1:0]      rsp_tuser,
   // tdata: out_key [39:0], out_payload [47:40], out_level [49:48], zero [55:50].
   output logic [tlpq_pkg::TDATA_W-1:0]       rsp_tdata
);
   import tlpq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // The sequencer walks IDLE -> SCAN -> DONE. The scan issues one memory read
   // per cycle; the registered read data is folded into the scan unit. DONE
   // commits the outcome once the result register is free.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;

   // Captured request.
   logic                   op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [PAYLOAD_W-1:0]   payload_ff, payload_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;

   // Scan pointers: read issue count and the index whose data is arriving.
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   cmp_en_ff, cmp_en_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;

   // Slot occupancy and the stamp source.
   logic [DEPTH-1:0]       slot_valid_ff, slot_valid_in;
   logic [STAMP_W-1:0]     counter_ff, counter_in;

   // Result register, parts the scan from the consumer.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_W-1:0]   rsp_payload_ff, rsp_payload_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;

   logic                   req_xfer;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   slot_entry_type         wr_data;
   slot_entry_type         rd_data;
   logic                   commit;

   scan_status_type        scan_status;
   logic [IDX_W-1:0]       free_idx;
   logic [IDX_W-1:0]       best_idx;
   slot_entry_type         best_entry;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // A result may be loaded when the output register is empty or being drained.
   assign commit  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rd_en   = (state_ff == S_SCAN) && (rd_cnt_ff != CNT_W'(DEPTH));
   assign rd_addr = rd_cnt_ff[IDX_W-1:0];

   // An accepted insert writes the lowest free slot. Writes happen only in
   // DONE, after every read of the scan has returned, so a read never meets a
   // write to the same entry.
   assign wr_en = commit && (op_ff == OP_INSERT) && !scan_status.dup
                  && scan_status.free_found;
   always_comb begin
      wr_data.key     = key_ff;
      wr_data.payload = payload_ff;
      wr_data.level   = level_ff;
      wr_data.stamp   = counter_ff;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      payload_in     = payload_ff;
      level_in       = level_ff;
      rd_cnt_in      = rd_cnt_ff;
      cmp_en_in      = rd_en;
      cmp_idx_in     = rd_addr;
      slot_valid_in  = slot_valid_ff;
      counter_in     = counter_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_level_in   = rsp_level_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in      = req_tuser;
               key_in     = req_tdata[KEY_W-1:0];
               payload_in = req_tdata[KEY_W+PAYLOAD_W-1:KEY_W];
               level_in   = req_tdata[KEY_W+PAYLOAD_W+LEVEL_W-1:KEY_W+PAYLOAD_W];
               // A level of zero is taken as the lowest level.
               if (level_in == LVL_NONE) begin
                  level_in = LVL_GREEN;
               end
               rd_cnt_in = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            end else if (!cmp_en_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_key_in     = '0;
               rsp_payload_in = '0;
               rsp_level_in   = LVL_NONE;
               if (op_ff == OP_INSERT) begin
                  if (scan_status.dup) begin
                     rsp_status_in = ST_DUP;
                  end else if (!scan_status.free_found) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     slot_valid_in[free_idx] = 1'b1;
                     counter_in              = counter_ff + STAMP_W'(1);
                  end
               end else begin
                  if (!scan_status.best_found) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     slot_valid_in[best_idx] = 1'b0;
                     rsp_key_in              = best_entry.key;
                     rsp_payload_in          = best_entry.payload;
                     rsp_level_in            = best_entry.level;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cmp_en_ff     <= 1'b0;
         slot_valid_ff <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_en_ff     <= cmp_en_in;
         slot_valid_ff <= slot_valid_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      payload_ff     <= payload_in;
      level_ff       <= level_in;
      cmp_idx_ff     <= cmp_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_level_ff   <= rsp_level_in;
   end

   tlpq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The scan unit is cleared as the request is taken, so its flags describe
   // only the pass made for this item.
   tlpq_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_xfer),
      .cmp_en     (cmp_en_ff),
      .cmp_idx    (cmp_idx_ff),
      .cmp_valid  (slot_valid_ff[cmp_idx_ff]),
      .cmp_entry  (rd_data),
      .req_key    (key_ff),
      .counter    (counter_ff),
      .status     (scan_status),
      .free_idx   (free_idx),
      .best_idx   (best_idx),
      .best_entry (best_entry)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(TDATA_W - KEY_W - PAYLOAD_W - LEVEL_W){1'b0}},
                        rsp_level_ff, rsp_payload_ff, rsp_key_ff};

endmodule

// ===== hdl/tlpq_checker.sv =====
// ---------------------------------------------------------------------------
// tlpq_checker: port-level checks of the priority queue
// Watches the request and result channels and tracks items in flight.
// ---------------------------------------------------------------------------
module tlpq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tlpq_pkg::STATUS_W-1:0]      rsp_tuser,
   input logic [tlpq_pkg::TDATA_W-1:0]       rsp_tdata
);
   import tlpq_pkg::*;

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff, pending_in;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The queue works on one item at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while an item is still being scanned");

   // Every result answers an accepted request.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> pending_ff != 2'd0)
      else $error("result transfer without a pending request");

   // Refused or empty results carry no entry.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("non-ok result carries entry data");

   // An entry level is reported only with an ok status.
   a_level_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[49:48] != LVL_NONE) |-> rsp_tuser == ST_OK)
      else $error("entry level reported with a failing status");

endmodule

bind three_level_priority_queue_unit tlpq_checker u_tlpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for three_level_priority_queue_unit
// Streams insert and dequeue requests into the queue. A shadow copy of the
// slot store predicts the status and the removed entry of every request.
// Each result transfer is checked field by field against the oldest
// prediction. Both stream sides idle at random, and the result side holds
// off once for a long stretch so that the queue backs up.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlpq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int IDLE_LIMIT   = 3000;  // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 40;    // wait after the last owed result before the verdict
   localparam int TAIL_ITEMS   = 120;   // the last requests go without idling
   localparam int HOLD_AT      = 300;   // request count that starts the long hold
   localparam int HOLD_CYCLES  = 400;

   // One request as the bench sees it, before packing onto the stream.
   typedef struct packed {
      logic                 op;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEVEL_W-1:0]   level;
   } queue_req_type;

   // One predicted result.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [LEVEL_W-1:0]   level;
   } queue_rsp_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = OP_INSERT;
   logic [TDATA_W-1:0]    req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic [TDATA_W-1:0]    rsp_tdata;

   // Requests still to be offered, and the results the queue still owes us.
   queue_req_type request_backlog[$];
   queue_rsp_type owed_results[$];
   queue_req_type on_bus;
   queue_rsp_type oldest_owed;

   // Shadow copy of the slot store and the arrival counter.
   logic                 shadow_used[DEPTH];
   logic [KEY_W-1:0]     shadow_key[DEPTH];
   logic [PAYLOAD_W-1:0] shadow_payload[DEPTH];
   logic [LEVEL_W-1:0]   shadow_level[DEPTH];
   logic [STAMP_W-1:0]   shadow_stamp[DEPTH];
   logic [STAMP_W-1:0]   shadow_arrivals;

   logic [KEY_W-1:0]     key_pool[24];

   int mismatch_count = 0;
   int req_count      = 0;
   int rsp_count      = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int quiet_cycles   = 0;

   three_level_priority_queue_unit #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow queue. Applies one accepted request to the shadow store and
   // returns the result the queue must give for it.
   // -------------------------------------------------------------------------
   function automatic queue_rsp_type apply_queue_request(input queue_req_type rq);
      queue_rsp_type      res;
      logic [LEVEL_W-1:0] lvl;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] best_age;
      logic [LEVEL_W-1:0] best_lvl;
      int                 free_idx;
      int                 best;
      bit                 dup;
      res      = '0;
      free_idx = -1;
      best     = -1;
      best_age = '0;
      best_lvl = LVL_NONE;
      dup      = 1'b0;
      if (rq.op == OP_INSERT) begin
         // A level of zero is stored as the lowest level.
         lvl = (rq.level == LVL_NONE) ? LVL_GREEN : rq.level;
         for (int i = 0; i < DEPTH; i++) begin
            if (shadow_used[i]) begin
               if (shadow_key[i] == rq.key)
                  dup = 1'b1;
            end else if (free_idx < 0) begin
               free_idx = i;
            end
         end
         // A duplicate key is reported even when the store is also full.
         if (dup) begin
            res.status = ST_DUP;
         end else if (free_idx < 0) begin
            res.status = ST_FULL;
         end else begin
            shadow_used[free_idx]    = 1'b1;
            shadow_key[free_idx]     = rq.key;
            shadow_payload[free_idx] = rq.payload;
            shadow_level[free_idx]   = lvl;
            shadow_stamp[free_idx]   = shadow_arrivals;
            shadow_arrivals          = shadow_arrivals + STAMP_W'(1);
            res.status               = ST_OK;
         end
      end else begin
         // Highest level wins, then the largest mod-256 age, then the lowest
         // slot, since only a strictly better candidate replaces the best.
         for (int i = 0; i < DEPTH; i++) begin
            if (shadow_used[i]) begin
               age = shadow_arrivals - shadow_stamp[i];
               if (best < 0 || shadow_level[i] > best_lvl ||
                   (shadow_level[i] == best_lvl && age > best_age)) begin
                  best     = i;
                  best_lvl = shadow_level[i];
                  best_age = age;
               end
            end
         end
         if (best < 0) begin
            res.status = ST_EMPTY;
         end else begin
            shadow_used[best] = 1'b0;
            res.status        = ST_OK;
            res.key           = shadow_key[best];
            res.payload       = shadow_payload[best];
            res.level         = shadow_level[best];
         end
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Request builders used by the stimulus below.
   // -------------------------------------------------------------------------
   function automatic logic [KEY_W-1:0] random_key();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[KEY_W-1:0];
   endfunction

   // Mostly keys from a small pool, so that duplicates come up often.
   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 6)
         return key_pool[$urandom_range(0, 23)];
      return random_key();
   endfunction

   // Level zero is outside the nominal range but still reaches the block.
   function automatic logic [LEVEL_W-1:0] pick_level();
      if ($urandom_range(0, 9) == 0)
         return LVL_NONE;
      return LEVEL_W'($urandom_range(1, 3));
   endfunction

   task automatic push_insert(input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p,
                              input logic [LEVEL_W-1:0] l);
      queue_req_type rq;
      rq.op      = OP_INSERT;
      rq.key     = k;
      rq.payload = p;
      rq.level   = l;
      request_backlog.push_back(rq);
   endtask

   // The key, payload and level of a dequeue are ignored, so they carry noise.
   task automatic push_dequeue();
      queue_req_type rq;
      rq.op      = OP_DEQUEUE;
      rq.key     = random_key();
      rq.payload = PAYLOAD_W'($urandom_range(0, 255));
      rq.level   = LEVEL_W'($urandom_range(0, 3));
      request_backlog.push_back(rq);
   endtask

   // Mixed traffic in phases of 60 requests. Each phase leans toward inserts,
   // balances, or leans toward dequeues, so the store swings between full and
   // empty and low-level entries linger under a churn of higher ones.
   task automatic push_churn(input int count);
      int ins_pct;
      int made;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 2))
            0:       ins_pct = 80;
            1:       ins_pct = 50;
            default: ins_pct = 25;
         endcase
         repeat (60) begin
            if ($urandom_range(0, 99) < ins_pct)
               push_insert(pick_key(), PAYLOAD_W'($urandom_range(0, 255)), pick_level());
            else
               push_dequeue();
            made++;
         end
      end
   endtask

   // Builds an age tie: a green entry, then 255 red entries that each leave
   // at once, then a second green entry with the same 8-bit stamp as the
   // first. Both greens have equal age, and the lower slot must leave first.
   task automatic push_stamp_wrap();
      logic [KEY_W-1:0] first_green;
      repeat (DEPTH) push_dequeue();
      first_green = random_key();
      push_insert(first_green, PAYLOAD_W'($urandom_range(0, 255)), LVL_GREEN);
      repeat (255) begin
         push_insert(random_key(), PAYLOAD_W'($urandom_range(0, 255)), LVL_RED);
         push_dequeue();
      end
      push_insert(first_green ^ KEY_W'(1), PAYLOAD_W'($urandom_range(0, 255)), LVL_GREEN);
      repeat (3) push_dequeue();
   endtask

   // -------------------------------------------------------------------------
   // Mismatch report. Prints one line (the first fifty only, to keep the log
   // short) and counts every mismatch.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                  rsp_count, what, got, want);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Request driver. A request is predicted at the edge where its transfer
   // happens. The next request goes on the bus as soon as the slot is free,
   // unless an idle burst is running. Bursts stop in calm stretches and in
   // the tail of the run.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed_results.push_back(apply_queue_request(on_bus));
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap--;
            end else if (request_backlog.size() > 0) begin
               on_bus = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.op;
               req_tdata  <= {6'b0, on_bus.level, on_bus.payload, on_bus.key};
               if (request_backlog.size() >= TAIL_ITEMS && (req_count / 128) % 4 != 3 &&
                   $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result receiver. Once, the receiver holds off for a long stretch while
   // the driver keeps offering requests, so the queue backs up and stops
   // accepting. Otherwise it stalls in short random bursts, except in calm
   // stretches and in the tail.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         rsp_tready <= 1'b0;
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (request_backlog.size() >= TAIL_ITEMS && (req_count / 128) % 4 != 1 &&
                   $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 15) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor. Every result transfer is matched against the oldest
   // owed result, field by field.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            report_mismatch("result with none owed", 64'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            oldest_owed = owed_results.pop_front();
            if (rsp_tuser !== oldest_owed.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(oldest_owed.status));
            if (rsp_tdata[39:0] !== oldest_owed.key)
               report_mismatch("out_key", 64'(rsp_tdata[39:0]), 64'(oldest_owed.key));
            if (rsp_tdata[47:40] !== oldest_owed.payload)
               report_mismatch("out_payload", 64'(rsp_tdata[47:40]),
                               64'(oldest_owed.payload));
            if (rsp_tdata[49:48] !== oldest_owed.level)
               report_mismatch("out_level", 64'(rsp_tdata[49:48]), 64'(oldest_owed.level));
         end
         rsp_count++;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog. Ends the run when no transfer happens on either side for too
   // long. The longest correct pause is the long hold plus one latency.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_used[i]    = 1'b0;
         shadow_key[i]     = '0;
         shadow_payload[i] = '0;
         shadow_level[i]   = LVL_NONE;
         shadow_stamp[i]   = '0;
      end
      shadow_arrivals = '0;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 24; i++)
         key_pool[i] = random_key();

      // Directed part. A dequeue on the empty queue, then sixteen inserts
      // that fill the store with extreme keys and payloads on every level
      // (level zero included), a duplicate key while full, a new key while
      // full, and dequeues that must come out red first.
      push_dequeue();
      push_insert('0, 8'h00, LVL_GREEN);
      push_insert('1, 8'hFF, LVL_RED);
      push_insert(40'h55_5555_5555, 8'hAA, LVL_NONE);
      push_insert(40'hAA_AAAA_AAAA, 8'h55, LVL_YELLOW);
      for (int i = 0; i < 12; i++)
         push_insert(KEY_W'(40'h80_0000_0000 >> i) | KEY_W'(i), PAYLOAD_W'(i * 21),
                     LEVEL_W'(i % 4));
      push_insert('0, 8'h11, LVL_RED);
      push_insert(40'h12_3456_789A, 8'h22, LVL_RED);
      repeat (4) push_dequeue();

      // Random part: deep churn, the stamp wrap tie, then more churn.
      push_churn(300);
      push_stamp_wrap();
      push_churn(300);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge, clear of the updates at the rising edge.
      do
         @(negedge clock);
      while (request_backlog.size() > 0 || req_tvalid || owed_results.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== three_level_priority_queue_unit.f =====
hdl/tlpq_pkg.sv
hdl/tlpq_mem.sv
hdl/tlpq_scan.sv
hdl/three_level_priority_queue_unit.sv
hdl/tlpq_checker.sv
sim/tb.sv
